// File: rtl/core/anamorphic_lens_undistort_point_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the anamorphic lens point unit
// Concurrent assertion shorthands, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ANAMORPHIC_LENS_UNDISTORT_POINT_UNIT_MACROS_SVH
`define ANAMORPHIC_LENS_UNDISTORT_POINT_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LUD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LUD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/lud_pkg.sv
// ---------------------------------------------------------------------------
// Lens point unit package
// Shared types, constants and saturating arithmetic helpers.
// ---------------------------------------------------------------------------
package lud_pkg;

	localparam int DATA_W          = 64;
	localparam int WORD_W          = 32;
	localparam int FRAC_BITS_DEF   = 28;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CFG_INDEX_W     = 3;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [DATA_W-1:0] RST_ROTATION = 64'h0000_0000_1000_0000;
	localparam logic [DATA_W-1:0] RST_SQUEEZE  = 64'h1000_0000_1000_0000;
	localparam logic [WORD_W-1:0] RST_INV_ASP  = 32'h1000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF_XQ   = 3'd0,
		REG_COEF_YQ   = 3'd1,
		REG_COEF_X4   = 3'd2,
		REG_COEF_Y4   = 3'd3,
		REG_FOURFOLD  = 3'd4,
		REG_ROTATION  = 3'd5,
		REG_SQUEEZE   = 3'd6,
		REG_INV_ASP   = 3'd7
	} lud_reg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] cx02;
		logic signed [WORD_W-1:0] cx22;
		logic signed [WORD_W-1:0] cy02;
		logic signed [WORD_W-1:0] cy22;
		logic signed [WORD_W-1:0] cx04;
		logic signed [WORD_W-1:0] cx24;
		logic signed [WORD_W-1:0] cy04;
		logic signed [WORD_W-1:0] cy24;
		logic signed [WORD_W-1:0] cx44;
		logic signed [WORD_W-1:0] cy44;
		logic signed [WORD_W-1:0] cos_a;
		logic signed [WORD_W-1:0] sin_a;
		logic signed [WORD_W-1:0] qx;
		logic signed [WORD_W-1:0] qy;
		logic signed [WORD_W-1:0] inva;
	} lud_coef_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] px;
		logic signed [DATA_W-1:0] py;
		logic                     origin;
	} lud_entry_t;

	typedef struct packed {
		logic                     ov;
		logic signed [DATA_W-1:0] v;
	} lud_sat_t;

	function automatic lud_sat_t sat_add(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		lud_sat_t r;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		r.ov = s[DATA_W] ^ s[DATA_W-1];
		r.v  = r.ov ? (s[DATA_W] ? SAT_MIN : SAT_MAX) : s[DATA_W-1:0];
		return r;
	endfunction

	function automatic lud_sat_t sat_sub(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		lud_sat_t r;
		s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		r.ov = s[DATA_W] ^ s[DATA_W-1];
		r.v  = r.ov ? (s[DATA_W] ? SAT_MIN : SAT_MAX) : s[DATA_W-1:0];
		return r;
	endfunction

	// Six times a value, saturated; equal to doubling, doubling and adding back.
	function automatic lud_sat_t sat_mul6(input logic signed [DATA_W-1:0] a);
		logic [DATA_W+2:0] e;
		logic [DATA_W+2:0] w;
		lud_sat_t r;
		e = {{3{a[DATA_W-1]}}, a};
		w = (e << 2) + (e << 1);
		r.ov = !(w[DATA_W+2:DATA_W-1] == 4'b0000 || w[DATA_W+2:DATA_W-1] == 4'b1111);
		r.v  = r.ov ? (w[DATA_W+2] ? SAT_MIN : SAT_MAX) : w[DATA_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/core/lud_if.sv
// ---------------------------------------------------------------------------
// Lens point unit channel interfaces
// Valid/ready channels for input points and mapped results.
// ---------------------------------------------------------------------------
interface lud_point_if #(parameter int COORD_WIDTH = lud_pkg::COORD_WIDTH_DEF) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;

	modport source(output valid, output point_x, output point_y, input ready);
	modport sink(input valid, input point_x, input point_y, output ready);
endinterface

interface lud_result_if #(parameter int COORD_WIDTH = lud_pkg::COORD_WIDTH_DEF) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] mapped_x;
	logic signed [COORD_WIDTH-1:0] mapped_y;
	logic                          clipped;

	modport source(output valid, output mapped_x, output mapped_y, output clipped,
		input ready);
	modport sink(input valid, input mapped_x, input mapped_y, input clipped,
		output ready);
endinterface

// File: rtl/core/lud_mul.sv
// ---------------------------------------------------------------------------
// Lens point unit fixed-point multiplier
// Four-stage 64 by 64 multiply from 32-bit partial products, rounded and
// saturated to signed 64 bits.
// ---------------------------------------------------------------------------
module lud_mul #(
	parameter int FRAC_BITS = lud_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [lud_pkg::DATA_W-1:0] a,
	input  logic signed [lud_pkg::DATA_W-1:0] b,
	output logic signed [lud_pkg::DATA_W-1:0] p,
	output logic                             ov
);
	import lud_pkg::*;

	localparam int PW = 2 * DATA_W;
	localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic [DATA_W-1:0] ua_s1, ub_s1;
	logic              neg_s1, neg_s2, neg_s3;
	logic [DATA_W-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [PW-1:0]     full_s3;
	logic [DATA_W-1:0] mag;
	logic              hi_nz;
	logic signed [DATA_W-1:0] res;
	logic              res_ov;

	always_comb begin
		hi_nz  = |full_s3[PW-1:DATA_W+FRAC_BITS];
		mag    = full_s3[DATA_W+FRAC_BITS-1:FRAC_BITS];
		res_ov = 1'b0;
		res    = mag;
		if (hi_nz) begin
			res_ov = 1'b1;
			res    = neg_s3 ? SAT_MIN : SAT_MAX;
		end else if (neg_s3) begin
			if (mag[DATA_W-1]) begin
				res_ov = |mag[DATA_W-2:0];
				res    = SAT_MIN;
			end else begin
				res = ~mag + {{(DATA_W-1){1'b0}}, 1'b1};
			end
		end else if (mag[DATA_W-1]) begin
			res_ov = 1'b1;
			res    = SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= a[DATA_W-1] ^ b[DATA_W-1];
			ua_s1   <= a[DATA_W-1] ? (~a + {{(DATA_W-1){1'b0}}, 1'b1}) : a;
			ub_s1   <= b[DATA_W-1] ? (~b + {{(DATA_W-1){1'b0}}, 1'b1}) : b;
			neg_s2  <= neg_s1;
			p00_s2  <= DATA_W'(ua_s1[WORD_W-1:0]) * DATA_W'(ub_s1[WORD_W-1:0]);
			p01_s2  <= DATA_W'(ua_s1[WORD_W-1:0]) * DATA_W'(ub_s1[DATA_W-1:WORD_W]);
			p10_s2  <= DATA_W'(ua_s1[DATA_W-1:WORD_W]) * DATA_W'(ub_s1[WORD_W-1:0]);
			p11_s2  <= DATA_W'(ua_s1[DATA_W-1:WORD_W]) * DATA_W'(ub_s1[DATA_W-1:WORD_W]);
			neg_s3  <= neg_s2;
			full_s3 <= {{DATA_W{1'b0}}, p00_s2}
				+ {{WORD_W{1'b0}}, p01_s2, {WORD_W{1'b0}}}
				+ {{WORD_W{1'b0}}, p10_s2, {WORD_W{1'b0}}}
				+ {p11_s2, {DATA_W{1'b0}}}
				+ HALF;
			p  <= res;
			ov <= res_ov;
		end
	end
endmodule

// File: rtl/core/lud_front.sv
// ---------------------------------------------------------------------------
// Lens point unit front end
// Takes input points, widens them and marks points at the origin.
// ---------------------------------------------------------------------------
module lud_front (
	input  logic                clk,
	input  logic                arst_n,
	lud_point_if.sink           point,
	output logic                push_valid,
	input  logic                push_ready,
	output lud_pkg::lud_entry_t push_data
);
	import lud_pkg::*;

	logic       vld_q;
	lud_entry_t entry_q;
	logic       take;

	assign point.ready = !vld_q || push_ready;
	assign take        = point.valid && point.ready;
	assign push_valid  = vld_q;
	assign push_data   = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (point.ready) begin
			vld_q <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_q.px     <= DATA_W'(point.point_x);
			entry_q.py     <= DATA_W'(point.point_y);
			entry_q.origin <= (point.point_x == '0) && (point.point_y == '0);
		end
	end
endmodule

// File: rtl/core/lud_queue.sv
// ---------------------------------------------------------------------------
// Lens point unit queue
// Short FIFO that decouples the front end from the arithmetic back end.
// ---------------------------------------------------------------------------
module lud_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  lud_pkg::lud_entry_t push_data,
	output logic                pop_valid,
	input  logic                pop,
	output lud_pkg::lud_entry_t pop_data
);
	import lud_pkg::*;
	`include "anamorphic_lens_undistort_point_unit_macros.svh"

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	lud_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`LUD_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
	`LUD_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, cnt_q != '0, "pop from empty queue")
	`LUD_ASSERT_NXT(a_cnt_grow, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow")
endmodule

// File: rtl/core/lud_back.sv
// ---------------------------------------------------------------------------
// Lens point unit back end
// Pipelined aspect-scale, rotate, polynomial, squeeze and rotate-back datapath with the
// output register. The whole pipe advances together when the output can move.
// ---------------------------------------------------------------------------
module lud_back #(
	parameter int FRAC_BITS   = lud_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = lud_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  lud_pkg::lud_entry_t q_data,
	output logic                q_pop,
	input  lud_pkg::lud_coef_t  coef,
	lud_result_if.source        result
);
	import lud_pkg::*;
	`include "anamorphic_lens_undistort_point_unit_macros.svh"

	localparam int LAST = 40;
	localparam logic signed [DATA_W-1:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [DATA_W-1:0] CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam logic signed [DATA_W-1:0] CMIN = -CMAX - 64'sd1;

	typedef logic signed [DATA_W-1:0] word_t;

	logic  en;
	logic  vld_s [0:LAST];
	logic  ov_s  [0:LAST];
	logic  org_s [0:LAST];
	logic  inj   [0:LAST];

	word_t px_s0;
	word_t py_s   [0:4];
	word_t rx_s   [9:27];
	word_t ry_s   [9:27];
	word_t xx_s14, yy_s14;
	word_t r2_s   [14:20];
	word_t r2c2_s [14:20];
	word_t r4_s   [19:20];
	word_t r4c2_s [19:20];
	word_t xx4_s19, yy4_s19, t_s19, r4c4_s20;
	word_t dx_s25, dx_s26, dx_s27, dy_s25, dy_s26, dy_s27;
	word_t x3_s25, x4_s25, x5_s25, x5_s26;
	word_t y3_s25, y4_s25, y5_s25, y5_s26;
	word_t ox_s40, oy_s40;

	logic  out_vld_q, out_clip_q;
	logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;

	// Multiplier results, named after the product, with their overflow flags.
	word_t xs_p, cxs_p, spy_p, sxs_p, cpy_p, xx_p, yy_p;
	word_t r4_p, r4c2_p, xxyy_p, xx4_p, yy4_p;
	word_t px1_p, px2_p, px3_p, px4_p, px5_p, py1_p, py2_p, py3_p, py4_p, py5_p;
	word_t ux_p, uy_p, sx_p, sy_p, csx_p, ssy_p, csy_p, ssx_p;
	logic  xs_o, cxs_o, spy_o, sxs_o, cpy_o, xx_o, yy_o;
	logic  r4_o, r4c2_o, xxyy_o, xx4_o, yy4_o;
	logic  px1_o, px2_o, px3_o, px4_o, px5_o, py1_o, py2_o, py3_o, py4_o, py5_o;
	logic  ux_o, uy_o, sx_o, sy_o, csx_o, ssy_o, csy_o, ssx_o;

	lud_sat_t rx_a, ry_a, r2_a, r2c2_a, t_a, u_a, r4c4_a;
	lud_sat_t dx1_a, dx2_a, dx3_a, dx4_a, dx5_a, dy1_a, dy2_a, dy3_a, dy4_a, dy5_a;
	lud_sat_t ox_a, oy_a;
	logic     clx, cly;
	logic signed [COORD_WIDTH-1:0] fx, fy;

	assign en    = !out_vld_q || result.ready;
	assign q_pop = en && q_valid;

	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_xs (.clk, .en, .a(px_s0), .b(DATA_W'(coef.inva)), .p(xs_p), .ov(xs_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_cxs (.clk, .en, .a(DATA_W'(coef.cos_a)), .b(xs_p), .p(cxs_p), .ov(cxs_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_spy (.clk, .en, .a(DATA_W'(coef.sin_a)), .b(py_s[4]), .p(spy_p), .ov(spy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_sxs (.clk, .en, .a(DATA_W'(coef.sin_a)), .b(xs_p), .p(sxs_p), .ov(sxs_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_cpy (.clk, .en, .a(DATA_W'(coef.cos_a)), .b(py_s[4]), .p(cpy_p), .ov(cpy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_xx (.clk, .en, .a(rx_s[9]), .b(rx_s[9]), .p(xx_p), .ov(xx_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_yy (.clk, .en, .a(ry_s[9]), .b(ry_s[9]), .p(yy_p), .ov(yy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_r4 (.clk, .en, .a(r2_s[14]), .b(r2_s[14]), .p(r4_p), .ov(r4_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_r4c2 (.clk, .en, .a(r2_s[14]), .b(r2c2_s[14]), .p(r4c2_p), .ov(r4c2_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_xxyy (.clk, .en, .a(xx_s14), .b(yy_s14), .p(xxyy_p), .ov(xxyy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_xx4 (.clk, .en, .a(xx_s14), .b(xx_s14), .p(xx4_p), .ov(xx4_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_yy4 (.clk, .en, .a(yy_s14), .b(yy_s14), .p(yy4_p), .ov(yy4_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_px1 (.clk, .en, .a(DATA_W'(coef.cx02)), .b(r2_s[20]), .p(px1_p), .ov(px1_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_px2 (.clk, .en, .a(DATA_W'(coef.cx04)), .b(r4_s[20]), .p(px2_p), .ov(px2_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_px3 (.clk, .en, .a(DATA_W'(coef.cx22)), .b(r2c2_s[20]), .p(px3_p), .ov(px3_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_px4 (.clk, .en, .a(DATA_W'(coef.cx24)), .b(r4c2_s[20]), .p(px4_p), .ov(px4_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_px5 (.clk, .en, .a(DATA_W'(coef.cx44)), .b(r4c4_s20), .p(px5_p), .ov(px5_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_py1 (.clk, .en, .a(DATA_W'(coef.cy02)), .b(r2_s[20]), .p(py1_p), .ov(py1_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_py2 (.clk, .en, .a(DATA_W'(coef.cy04)), .b(r4_s[20]), .p(py2_p), .ov(py2_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_py3 (.clk, .en, .a(DATA_W'(coef.cy22)), .b(r2c2_s[20]), .p(py3_p), .ov(py3_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_py4 (.clk, .en, .a(DATA_W'(coef.cy24)), .b(r4c2_s[20]), .p(py4_p), .ov(py4_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_py5 (.clk, .en, .a(DATA_W'(coef.cy44)), .b(r4c4_s20), .p(py5_p), .ov(py5_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ux (.clk, .en, .a(rx_s[27]), .b(dx_s27), .p(ux_p), .ov(ux_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_uy (.clk, .en, .a(ry_s[27]), .b(dy_s27), .p(uy_p), .ov(uy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_sx (.clk, .en, .a(ux_p), .b(DATA_W'(coef.qx)), .p(sx_p), .ov(sx_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_sy (.clk, .en, .a(uy_p), .b(DATA_W'(coef.qy)), .p(sy_p), .ov(sy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_csx (.clk, .en, .a(DATA_W'(coef.cos_a)), .b(sx_p), .p(csx_p), .ov(csx_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ssy (.clk, .en, .a(DATA_W'(coef.sin_a)), .b(sy_p), .p(ssy_p), .ov(ssy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_csy (.clk, .en, .a(DATA_W'(coef.cos_a)), .b(sy_p), .p(csy_p), .ov(csy_o));
	lud_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ssx (.clk, .en, .a(DATA_W'(coef.sin_a)), .b(sx_p), .p(ssx_p), .ov(ssx_o));

	// Saturating sums, in the order the mapping defines them.
	always_comb begin
		rx_a   = sat_sub(cxs_p, spy_p);
		ry_a   = sat_add(sxs_p, cpy_p);
		r2_a   = sat_add(xx_p, yy_p);
		r2c2_a = sat_sub(xx_p, yy_p);
		t_a    = sat_mul6(xxyy_p);
		u_a    = sat_sub(xx4_s19, t_s19);
		r4c4_a = sat_add(u_a.v, yy4_s19);
		dx1_a  = sat_add(ONE, px1_p);
		dx2_a  = sat_add(dx1_a.v, px2_p);
		dx3_a  = sat_add(dx_s25, x3_s25);
		dx4_a  = sat_add(dx3_a.v, x4_s25);
		dx5_a  = sat_add(dx_s26, x5_s26);
		dy1_a  = sat_add(ONE, py1_p);
		dy2_a  = sat_add(dy1_a.v, py2_p);
		dy3_a  = sat_add(dy_s25, y3_s25);
		dy4_a  = sat_add(dy3_a.v, y4_s25);
		dy5_a  = sat_add(dy_s26, y5_s26);
		ox_a   = sat_add(csx_p, ssy_p);
		oy_a   = sat_sub(csy_p, ssx_p);
	end

	// Overflow events, indexed by the pipeline cycle in which they are seen.
	always_comb begin
		for (int k = 0; k <= LAST; k++) begin
			inj[k] = 1'b0;
		end
		inj[4]  = xs_o;
		inj[8]  = cxs_o | spy_o | sxs_o | cpy_o | rx_a.ov | ry_a.ov;
		inj[13] = xx_o | yy_o | r2_a.ov | r2c2_a.ov;
		inj[18] = r4_o | r4c2_o | xxyy_o | xx4_o | yy4_o | t_a.ov;
		inj[19] = u_a.ov | r4c4_a.ov;
		inj[24] = px1_o | px2_o | px3_o | px4_o | px5_o | py1_o | py2_o | py3_o
			| py4_o | py5_o | dx1_a.ov | dx2_a.ov | dy1_a.ov | dy2_a.ov;
		inj[25] = dx3_a.ov | dx4_a.ov | dy3_a.ov | dy4_a.ov;
		inj[26] = dx5_a.ov | dy5_a.ov;
		inj[31] = ux_o | uy_o;
		inj[35] = sx_o | sy_o;
		inj[39] = csx_o | ssy_o | csy_o | ssx_o | ox_a.ov | oy_a.ov;
	end

	always_comb begin
		clx = (ox_s40 > CMAX) || (ox_s40 < CMIN);
		cly = (oy_s40 > CMAX) || (oy_s40 < CMIN);
		fx  = (ox_s40 > CMAX) ? COORD_WIDTH'(CMAX)
			: ((ox_s40 < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(ox_s40));
		fy  = (oy_s40 > CMAX) ? COORD_WIDTH'(CMAX)
			: ((oy_s40 < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(oy_s40));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= q_valid;
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			out_vld_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s0    <= q_data.px;
			py_s[0]  <= q_data.py;
			ov_s[0]  <= 1'b0;
			org_s[0] <= q_data.origin;
			for (int k = 1; k <= LAST; k++) begin
				ov_s[k]  <= ov_s[k-1] | inj[k-1];
				org_s[k] <= org_s[k-1];
			end
			for (int k = 1; k <= 4; k++) begin
				py_s[k] <= py_s[k-1];
			end
			rx_s[9] <= rx_a.v;
			ry_s[9] <= ry_a.v;
			for (int k = 10; k <= 27; k++) begin
				rx_s[k] <= rx_s[k-1];
				ry_s[k] <= ry_s[k-1];
			end
			xx_s14     <= xx_p;
			yy_s14     <= yy_p;
			r2_s[14]   <= r2_a.v;
			r2c2_s[14] <= r2c2_a.v;
			for (int k = 15; k <= 20; k++) begin
				r2_s[k]   <= r2_s[k-1];
				r2c2_s[k] <= r2c2_s[k-1];
			end
			r4_s[19]   <= r4_p;
			r4_s[20]   <= r4_s[19];
			r4c2_s[19] <= r4c2_p;
			r4c2_s[20] <= r4c2_s[19];
			xx4_s19    <= xx4_p;
			yy4_s19    <= yy4_p;
			t_s19      <= t_a.v;
			r4c4_s20   <= r4c4_a.v;
			dx_s25     <= dx2_a.v;
			dy_s25     <= dy2_a.v;
			x3_s25     <= px3_p;
			x4_s25     <= px4_p;
			x5_s25     <= px5_p;
			x5_s26     <= x5_s25;
			y3_s25     <= py3_p;
			y4_s25     <= py4_p;
			y5_s25     <= py5_p;
			y5_s26     <= y5_s25;
			dx_s26     <= dx4_a.v;
			dy_s26     <= dy4_a.v;
			dx_s27     <= dx5_a.v;
			dy_s27     <= dy5_a.v;
			ox_s40     <= ox_a.v;
			oy_s40     <= oy_a.v;
			// A point at the origin maps to the origin with no clipping.
			out_x_q    <= org_s[LAST] ? '0 : fx;
			out_y_q    <= org_s[LAST] ? '0 : fy;
			out_clip_q <= org_s[LAST] ? 1'b0 : (ov_s[LAST] | clx | cly);
		end
	end

	assign result.valid    = out_vld_q;
	assign result.mapped_x = out_x_q;
	assign result.mapped_y = out_y_q;
	assign result.clipped  = out_clip_q;

	`LUD_ASSERT_IMP(a_origin_zero, clk, arst_n, vld_s[LAST] && org_s[LAST], ox_s40 == '0 && oy_s40 == '0 && !ov_s[LAST], "origin point did not map to zero")
	`LUD_ASSERT_NXT(a_out_load, clk, arst_n, en && vld_s[LAST], out_vld_q, "finished transaction not loaded")
	`LUD_ASSERT_NXT(a_pipe_hold, clk, arst_n, !en, $stable(vld_s[LAST]) && $stable(vld_s[0]), "pipe moved while stalled")
endmodule

// File: rtl/core/anamorphic_lens_undistort_point_unit.sv
// ---------------------------------------------------------------------------
// Anamorphic lens point unit
// Maps normalized points through the degree-4 anamorphic lens polynomial.
// ---------------------------------------------------------------------------
// The unit takes one point per clock and returns one mapped point per clock
// at a sustained rate while the result side keeps up. An accepted point passes
// through the front register, the queue, the arithmetic pipe and the output
// register before its result is valid. The latency is set by the eight
// dependent levels of 64-bit multiplies, each pipelined, and the saturating
// add stages between them. When the result side stalls the whole pipe holds
// and the four-entry queue absorbs points already in flight.
// Configuration must be written only while no transaction is in flight.
module anamorphic_lens_undistort_point_unit #(
	parameter int FRAC_BITS   = lud_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = lud_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lud_point_if.sink                           point,
	lud_result_if.source                        result,
	input  logic                                cfg_en,
	input  logic [lud_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lud_pkg::DATA_W-1:0]          cfg_data
);
	import lud_pkg::*;

	logic [DATA_W-1:0] xq_q, yq_q, x4_q, y4_q, ff_q, rot_q, sq_q;
	logic [WORD_W-1:0] inva_q;
	lud_coef_t         coef;

	logic       push_valid, push_ready, pop_valid, pop;
	lud_entry_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xq_q   <= '0;
			yq_q   <= '0;
			x4_q   <= '0;
			y4_q   <= '0;
			ff_q   <= '0;
			rot_q  <= RST_ROTATION;
			sq_q   <= RST_SQUEEZE;
			inva_q <= RST_INV_ASP;
		end else if (cfg_en) begin
			unique case (lud_reg_t'(cfg_index))
				REG_COEF_XQ:  xq_q   <= cfg_data;
				REG_COEF_YQ:  yq_q   <= cfg_data;
				REG_COEF_X4:  x4_q   <= cfg_data;
				REG_COEF_Y4:  y4_q   <= cfg_data;
				REG_FOURFOLD: ff_q   <= cfg_data;
				REG_ROTATION: rot_q  <= cfg_data;
				REG_SQUEEZE:  sq_q   <= cfg_data;
				REG_INV_ASP:  inva_q <= cfg_data[WORD_W-1:0];
			endcase
		end
	end

	always_comb begin
		coef.cx02  = xq_q[WORD_W-1:0];
		coef.cx22  = xq_q[DATA_W-1:WORD_W];
		coef.cy02  = yq_q[WORD_W-1:0];
		coef.cy22  = yq_q[DATA_W-1:WORD_W];
		coef.cx04  = x4_q[WORD_W-1:0];
		coef.cx24  = x4_q[DATA_W-1:WORD_W];
		coef.cy04  = y4_q[WORD_W-1:0];
		coef.cy24  = y4_q[DATA_W-1:WORD_W];
		coef.cx44  = ff_q[WORD_W-1:0];
		coef.cy44  = ff_q[DATA_W-1:WORD_W];
		coef.cos_a = rot_q[WORD_W-1:0];
		coef.sin_a = rot_q[DATA_W-1:WORD_W];
		coef.qx    = sq_q[WORD_W-1:0];
		coef.qy    = sq_q[DATA_W-1:WORD_W];
		coef.inva  = inva_q;
	end

	lud_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point      (point),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lud_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	lud_back #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_data  (pop_data),
		.q_pop   (pop),
		.coef    (coef),
		.result  (result)
	);
endmodule

// File: verif/anamorphic_lens_undistort_point_unit_tb.sv
// ---------------------------------------------------------------------------
// Anamorphic lens point unit testbench
// Drives points through the valid/ready channels under random gaps and stalls,
// writes several coefficient settings between phases and checks every mapped
// point against an in-bench fixed-point predictor or, if directed, its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module anamorphic_lens_undistort_point_unit_tb;
	import lud_pkg::*;

	localparam int FRAC = 28;
	localparam int CW = 32;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int DRAIN_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 600000;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic signed [CW-1:0] mx;
		logic signed [CW-1:0] my;
		logic                 clip;
	} mapped_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} point_row_t;

	logic clk;
	logic arst_n;
	logic cfg_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	lud_point_if #(.COORD_WIDTH(CW)) point();
	lud_result_if #(.COORD_WIDTH(CW)) result();

	anamorphic_lens_undistort_point_unit #(.FRAC_BITS(FRAC), .COORD_WIDTH(CW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.point(point),
		.result(result),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [63:0] lens_regs [8];
	mapped_t pending_maps [$];
	bit fault;
	bit no_gaps;
	bit pred_ov;
	longint cycle_count;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Rounded Q-format product, saturated to 64 bits.
	function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] p;
		logic [63:0] m;
		bit neg;
		neg = a[63] ^ b[63];
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		p = p + (128'd1 << (FRAC - 1));
		if (p[127:64+FRAC] != 0) begin
			pred_ov = 1'b1;
			return neg ? S64_MIN : S64_MAX;
		end
		m = p[63+FRAC:FRAC];
		if (neg) begin
			if (m >= 64'h8000_0000_0000_0000) begin
				if (m != 64'h8000_0000_0000_0000)
					pred_ov = 1'b1;
				return S64_MIN;
			end
			return -$signed(m);
		end
		if (m[63]) begin
			pred_ov = 1'b1;
			return S64_MAX;
		end
		return $signed(m);
	endfunction

	function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			pred_ov = 1'b1;
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			pred_ov = 1'b1;
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [CW-1:0] clamp_coord(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			pred_ov = 1'b1;
			return hi[CW-1:0];
		end
		if (v < lo) begin
			pred_ov = 1'b1;
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	function automatic logic signed [63:0] lo_w(input logic [63:0] r);
		return {{32{r[31]}}, r[31:0]};
	endfunction

	function automatic logic signed [63:0] hi_w(input logic [63:0] r);
		return {{32{r[63]}}, r[63:32]};
	endfunction

	function automatic logic signed [63:0] distortion(input logic signed [63:0] k2,
		input logic signed [63:0] k4, input logic signed [63:0] a2,
		input logic signed [63:0] a24, input logic signed [63:0] a44,
		input logic signed [63:0] r2, input logic signed [63:0] r4,
		input logic signed [63:0] r4c2, input logic signed [63:0] r2c2,
		input logic signed [63:0] r4c4);
		logic signed [63:0] d;
		d = 64'sd1 <<< FRAC;
		d = q_add(d, q_mul(k2, r2));
		d = q_add(d, q_mul(k4, r4));
		d = q_add(d, q_mul(a2, r2c2));
		d = q_add(d, q_mul(a24, r4c2));
		d = q_add(d, q_mul(a44, r4c4));
		return d;
	endfunction

	function automatic mapped_t lens_map_point(input logic signed [CW-1:0] px,
		input logic signed [CW-1:0] py);
		logic signed [63:0] c, s, qx, qy, inva, xs, rx, ry, xx, yy, xxyy;
		logic signed [63:0] r2, r4, r2c2, r4c2, r4c4, t, dx, dy, ux, uy, sx, sy, ox, oy;
		mapped_t m;
		pred_ov = 1'b0;
		c = lo_w(lens_regs[REG_ROTATION]);
		s = hi_w(lens_regs[REG_ROTATION]);
		qx = lo_w(lens_regs[REG_SQUEEZE]);
		qy = hi_w(lens_regs[REG_SQUEEZE]);
		inva = lo_w(lens_regs[REG_INV_ASP]);
		xs = q_mul(64'(px), inva);
		rx = q_sub(q_mul(c, xs), q_mul(s, 64'(py)));
		ry = q_add(q_mul(s, xs), q_mul(c, 64'(py)));
		xx = q_mul(rx, rx);
		yy = q_mul(ry, ry);
		r2 = q_add(xx, yy);
		r4 = q_mul(r2, r2);
		r2c2 = q_sub(xx, yy);
		r4c2 = q_mul(r2, r2c2);
		xxyy = q_mul(xx, yy);
		t = q_add(xxyy, xxyy);
		t = q_add(q_add(t, t), t);
		r4c4 = q_add(q_sub(q_mul(xx, xx), t), q_mul(yy, yy));
		dx = distortion(lo_w(lens_regs[REG_COEF_XQ]), lo_w(lens_regs[REG_COEF_X4]),
			hi_w(lens_regs[REG_COEF_XQ]), hi_w(lens_regs[REG_COEF_X4]),
			lo_w(lens_regs[REG_FOURFOLD]), r2, r4, r4c2, r2c2, r4c4);
		dy = distortion(lo_w(lens_regs[REG_COEF_YQ]), lo_w(lens_regs[REG_COEF_Y4]),
			hi_w(lens_regs[REG_COEF_YQ]), hi_w(lens_regs[REG_COEF_Y4]),
			hi_w(lens_regs[REG_FOURFOLD]), r2, r4, r4c2, r2c2, r4c4);
		ux = q_mul(rx, dx);
		uy = q_mul(ry, dy);
		sx = q_mul(ux, qx);
		sy = q_mul(uy, qy);
		ox = q_add(q_mul(c, sx), q_mul(s, sy));
		oy = q_sub(q_mul(c, sy), q_mul(s, sx));
		m.mx = clamp_coord(ox);
		m.my = clamp_coord(oy);
		m.clip = pred_ov;
		return m;
	endfunction

	// Mostly values near the unit range, with extremes and raw words mixed in.
	function automatic logic [31:0] rand_word(input int spread);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	task automatic write_reg(input lud_reg_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_en <= 1'b0;
		lens_regs[idx] = (idx == REG_INV_ASP) ? {32'd0, val[31:0]} : val;
	endtask

	// The point channel goes idle first so that nothing is taken twice.
	task automatic drain();
		point.valid <= 1'b0;
		wait (pending_maps.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Transaction on the point channel; the expectation is queued on acceptance.
	task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input bit typed, input mapped_t typed_map);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			point.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point.valid <= 1'b1;
		point.point_x <= x;
		point.point_y <= y;
		do @(posedge clk); while (!point.ready);
		pending_maps.push_back(typed ? typed_map : lens_map_point(x, y));
		@(negedge clk);
	endtask

	task automatic configure(input int phase);
		int unit_q;
		unit_q = 1 << FRAC;
		if (phase == N_PHASES - 1) begin
			// Largest magnitudes: heavy saturation everywhere.
			write_reg(REG_COEF_XQ, 64'h7FFF_FFFF_8000_0000);
			write_reg(REG_COEF_YQ, 64'h8000_0000_7FFF_FFFF);
			write_reg(REG_COEF_X4, 64'h7FFF_FFFF_7FFF_FFFF);
			write_reg(REG_COEF_Y4, 64'h8000_0000_8000_0000);
			write_reg(REG_FOURFOLD, 64'hFFFF_FFFF_7FFF_FFFF);
			write_reg(REG_ROTATION, 64'h8000_0000_7FFF_FFFF);
			write_reg(REG_SQUEEZE, 64'h7FFF_FFFF_8000_0000);
			write_reg(REG_INV_ASP, 64'hFFFF_FFFF_7FFF_FFFF);
		end else begin
			write_reg(REG_COEF_XQ, {rand_word(unit_q / 4), rand_word(unit_q / 4)});
			write_reg(REG_COEF_YQ, {rand_word(unit_q / 4), rand_word(unit_q / 4)});
			write_reg(REG_COEF_X4, {rand_word(unit_q / 16), rand_word(unit_q / 16)});
			write_reg(REG_COEF_Y4, {rand_word(unit_q / 16), rand_word(unit_q / 16)});
			write_reg(REG_FOURFOLD, {rand_word(unit_q / 16), rand_word(unit_q / 16)});
			write_reg(REG_ROTATION, {rand_word(unit_q), rand_word(unit_q)});
			write_reg(REG_SQUEEZE, {rand_word(2 * unit_q), rand_word(2 * unit_q)});
			write_reg(REG_INV_ASP, {$urandom, rand_word(2 * unit_q)});
		end
	endtask

	// Result side: a random stall before each transaction, none in quiet phases.
	initial begin
		result.ready = 1'b0;
		wait (arst_n);
		forever begin
			int stall;
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			mapped_t want;
			if (pending_maps.size() == 0) begin
				$error("mapped point arrived with none expected");
				fault = 1'b1;
			end else begin
				want = pending_maps.pop_front();
				if (result.mapped_x !== want.mx) begin
					$error("mapped_x: expected %0d, actual %0d", want.mx, result.mapped_x);
					fault = 1'b1;
				end
				if (result.mapped_y !== want.my) begin
					$error("mapped_y: expected %0d, actual %0d", want.my, result.mapped_y);
					fault = 1'b1;
				end
				if (result.clipped !== want.clip) begin
					$error("clipped: expected %0b, actual %0b", want.clip, result.clipped);
					fault = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		point_row_t directed [$];
		mapped_t m;
		int unit_q;
		unit_q = 1 << FRAC;
		fault = 1'b0;
		no_gaps = 1'b0;
		cycle_count = 0;
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		point.valid = 1'b0;
		point.point_x = '0;
		point.point_y = '0;
		lens_regs = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
			RST_ROTATION, RST_SQUEEZE, {32'd0, RST_INV_ASP}};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// With the reset settings the mapping is the identity, so the
		// expected point is the input itself, unclipped, at the extremes too.
		directed = '{
			'{32'sd0, 32'sd0},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h8000_0000, 32'h8000_0000},
			'{32'h7FFF_FFFF, 32'h8000_0000},
			'{32'h8000_0000, 32'h7FFF_FFFF},
			'{32'hFFFF_FFFF, 32'h0000_0001},
			'{32'h1000_0000, 32'h0000_0000},
			'{32'h0000_0000, 32'hF000_0000},
			'{32'h5555_5555, 32'hAAAA_AAAA},
			'{32'hAAAA_AAAA, 32'h5555_5555}
		};
		foreach (directed[i]) begin
			m.mx = directed[i].x;
			m.my = directed[i].y;
			m.clip = 1'b0;
			send_point(directed[i].x, directed[i].y, 1'b1, m);
		end
		drain();

		// Output out of range: eight times the inverse aspect pushes x past the limit.
		write_reg(REG_INV_ASP, 64'h7FFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'sd0, 1'b0, m);
		send_point(32'h8000_0000, 32'h4000_0000, 1'b0, m);
		send_point(32'sd0, 32'sd0, 1'b0, m);
		drain();

		for (int phase = 0; phase < N_PHASES; phase++) begin
			configure(phase);
			no_gaps = (phase % 3 == 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2 && phase == 2) begin
					point.valid <= 1'b0;
					wait (pending_maps.size() == 0);
					@(negedge clk);
				end
				if ($urandom_range(0, 3) == 0)
					send_point($urandom, $urandom, 1'b0, m);
				else
					send_point(rand_word(unit_q), rand_word(unit_q), 1'b0, m);
			end
			point.valid <= 1'b0;
			drain();
		end

		if (!fault)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
